// ===== design/scr_pod_pkg.sv =====
`timescale 1ns / 1ps
// scr_pod_pkg: types and fixed widths for the skin conductance response detector
// no dependencies; imported by scr_peak_onset_detector
package scr_pod_pkg;

  localparam int SAMPLE_W   = 32;  // phasic sample, two's complement
  localparam int AMP_W      = 31;  // min_rise_amplitude register
  localparam int LAG_W      = 7;   // rise_lag field
  localparam int MEAN_W     = 23;  // Q7.16 running mean
  localparam int FRAC_W     = 16;
  localparam int SPREAD_W   = 48;  // Q32.16 spread sum
  localparam int COUNT_W    = 32;  // response counter
  localparam int OUT_DATA_W = 144; // 142 field bits padded to bytes

  localparam logic [AMP_W-1:0] AMP_RESET = 31'd439805;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_SCAN  = 9'b000000010,
    ST_DRAIN = 9'b000000100,
    ST_CHECK = 9'b000001000,
    ST_DIV   = 9'b000010000,
    ST_NEWM  = 9'b000100000,
    ST_MUL   = 9'b001000000,
    ST_ACC   = 9'b010000000,
    ST_FIN   = 9'b100000000
  } state_e;

endpackage

// ===== design/scr_peak_onset_detector.sv =====
`timescale 1ns / 1ps
// scr_peak_onset_detector: peak and onset detection over a sample history window
// depends on scr_pod_pkg
// flow: a word with no local maximum goes from accept straight to the finish state and the
//   result register; with a local maximum the window scan reads the searched lags in turn
//   (up to WINDOW_DEPTH-1), then drains the read and compare, and a response adds a serial
//   divide plus the mean and spread update (ST_NEWM, ST_MUL, ST_ACC) before ST_FIN
// throughput: one word at a time, taken only in idle once the last result is loaded;
//   limited by the single window read port, the bit-serial mean divider and output stalls
// reset: all registers but the window read data clear; unwritten entries read as zero (fill count)
module scr_peak_onset_detector
  import scr_pod_pkg::*;
#(
  parameter int WINDOW_DEPTH = 96
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config
  input  logic                  cfg_we_i,
  input  logic [AMP_W-1:0]      cfg_wdata_i,   // min_rise_amplitude
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [SAMPLE_W-1:0]   s_axis_tdata,  // [31:0] phasic_sample
  // output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [31:0] peak_value, [63:32] onset_value, [70:64] rise_lag,
  // [93:71] mean_rise_lag, [141:94] rise_spread_sum, [143:142] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tuser   // response_found
);

  localparam int PTR_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W = PTR_W + 1;
  localparam logic [PTR_W-1:0] DEPTH_LAST = PTR_W'(WINDOW_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT  = CNT_W'(WINDOW_DEPTH);
  localparam logic [4:0]       DIV_LAST   = 5'(MEAN_W - 1);

  state_e state_q, state_d;

  // window memory
  logic [SAMPLE_W-1:0] win_mem [WINDOW_DEPTH];
  logic [SAMPLE_W-1:0] rd_data_q;

  logic [AMP_W-1:0]    amp_q;
  logic [PTR_W-1:0]    wp_q, rd_ptr_q, lag_q, lim_q, refr_q;
  logic [CNT_W-1:0]    fill_q;
  logic [SAMPLE_W-1:0] last_q, second_q, pk_q, low_q;
  logic [PTR_W-1:0]    low_lag_q;

  // read pipeline beside the memory
  logic                rd_vld_q, rd_ok_q, rd_first_q;
  logic [PTR_W-1:0]    rd_lag_q;

  // statistics
  logic [COUNT_W-1:0]  cnt_q, divisor_q;
  logic [MEAN_W-1:0]   mean_q, t_q, quo_q;
  logic [COUNT_W-1:0]  rem_q;
  logic                neg_q;
  logic [4:0]          div_cnt_q;
  logic [MEAN_W:0]     a_q, b_q;
  logic [2*MEAN_W+1:0] prod_q;
  logic [SPREAD_W-1:0] spread_q;

  // result register
  logic                resp_q;
  logic                out_vld_q, out_found_q;
  logic [SAMPLE_W-1:0] out_peak_q, out_onset_q;
  logic [LAG_W-1:0]    out_rise_q;
  logic [MEAN_W-1:0]   out_mean_q;
  logic [SPREAD_W-1:0] out_spread_q;

  logic                in_fire, local_max, found, fin_load;
  logic [PTR_W-1:0]    wp_nxt, refr_dec, lim_nxt;
  logic [SAMPLE_W-1:0] rd_val;
  logic [SAMPLE_W:0]   rise_amp;
  logic [LAG_W-1:0]    rise;
  logic [MEAN_W-1:0]   t_val;
  logic [MEAN_W+1:0]   diff_m, mag_m, new_m, a_m, b_m;
  logic [COUNT_W-1:0]  cnt_nxt;
  logic [COUNT_W:0]    rem_sh;
  logic                rem_ge;
  logic [SPREAD_W:0]   spread_sum;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign fin_load      = (state_q == ST_FIN) && (!out_vld_q || m_axis_tready);

  assign wp_nxt    = (wp_q == DEPTH_LAST) ? '0 : wp_q + 1'b1;
  assign refr_dec  = (refr_q != '0) ? refr_q - 1'b1 : '0;
  // refractory at its top leaves only lag 1
  assign lim_nxt   = (refr_dec == DEPTH_LAST) ? PTR_W'(1) : DEPTH_LAST - refr_dec;
  assign local_max = ($signed(last_q) > $signed(second_q)) &&
                     ($signed(last_q) > $signed(s_axis_tdata));

  assign rd_val   = rd_ok_q ? rd_data_q : '0;
  assign rise_amp = {pk_q[SAMPLE_W-1], pk_q} - {low_q[SAMPLE_W-1], low_q};
  assign found    = $signed(rise_amp) > $signed({2'b00, amp_q});
  assign rise     = LAG_W'(low_lag_q);
  assign t_val    = {rise, {FRAC_W{1'b0}}};
  assign diff_m   = {2'b00, t_val} - {2'b00, mean_q};
  assign mag_m    = diff_m[MEAN_W+1] ? -diff_m : diff_m;
  assign cnt_nxt  = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;

  assign rem_sh = {rem_q, quo_q[MEAN_W-1]};
  assign rem_ge = rem_sh >= {1'b0, divisor_q};

  // quotient truncates toward zero, so its sign follows the difference
  assign new_m = neg_q ? {2'b00, mean_q} - {2'b00, quo_q} : {2'b00, mean_q} + {2'b00, quo_q};
  assign a_m   = {2'b00, t_q} - new_m;
  assign b_m   = {2'b00, t_q} - {2'b00, mean_q};

  assign spread_sum = {1'b0, spread_q} + (SPREAD_W + 1)'(prod_q >> FRAC_W);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_fire) state_d = local_max ? ST_SCAN : ST_FIN;
      ST_SCAN:  if (lag_q == lim_q) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_CHECK;
      ST_CHECK: state_d = found ? ST_DIV : ST_FIN;
      ST_DIV:   if (div_cnt_q == '0) state_d = ST_NEWM;
      ST_NEWM:  state_d = ST_MUL;
      ST_MUL:   state_d = ST_ACC;
      ST_ACC:   state_d = ST_FIN;
      ST_FIN:   if (fin_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      win_mem[wp_nxt] <= s_axis_tdata;
    end
    rd_data_q <= win_mem[rd_ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      amp_q        <= AMP_RESET;
      wp_q         <= '0;
      rd_ptr_q     <= '0;
      lag_q        <= '0;
      lim_q        <= '0;
      refr_q       <= '0;
      fill_q       <= '0;
      last_q       <= '0;
      second_q     <= '0;
      pk_q         <= '0;
      low_q        <= '0;
      low_lag_q    <= '0;
      rd_vld_q     <= 1'b0;
      rd_ok_q      <= 1'b0;
      rd_first_q   <= 1'b0;
      rd_lag_q     <= '0;
      cnt_q        <= '0;
      divisor_q    <= '0;
      mean_q       <= '0;
      t_q          <= '0;
      quo_q        <= '0;
      rem_q        <= '0;
      neg_q        <= 1'b0;
      div_cnt_q    <= '0;
      a_q          <= '0;
      b_q          <= '0;
      prod_q       <= '0;
      spread_q     <= '0;
      resp_q       <= 1'b0;
      out_vld_q    <= 1'b0;
      out_found_q  <= 1'b0;
      out_peak_q   <= '0;
      out_onset_q  <= '0;
      out_rise_q   <= '0;
      out_mean_q   <= '0;
      out_spread_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        amp_q <= cfg_wdata_i;
      end

      rd_vld_q <= (state_q == ST_SCAN);
      if (fin_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            wp_q     <= wp_nxt;
            fill_q   <= (fill_q == DEPTH_CNT) ? fill_q : fill_q + 1'b1;
            refr_q   <= refr_dec;
            second_q <= last_q;
            last_q   <= s_axis_tdata;
            pk_q     <= last_q;
            rd_ptr_q <= wp_q;  // lag 1 sits at the old write pointer
            lag_q    <= PTR_W'(1);
            lim_q    <= lim_nxt;
            resp_q   <= 1'b0;
          end
        end
        ST_SCAN: begin
          rd_lag_q   <= lag_q;
          rd_first_q <= (lag_q == PTR_W'(1));
          rd_ok_q    <= {1'b0, lag_q} < fill_q;
          rd_ptr_q   <= (rd_ptr_q == '0) ? DEPTH_LAST : rd_ptr_q - 1'b1;
          lag_q      <= lag_q + 1'b1;
        end
        ST_CHECK: begin
          resp_q <= found;
          if (found) begin
            refr_q    <= DEPTH_LAST;
            cnt_q     <= cnt_nxt;
            divisor_q <= cnt_nxt;
            t_q       <= t_val;
            neg_q     <= diff_m[MEAN_W+1];
            quo_q     <= mag_m[MEAN_W-1:0];
            rem_q     <= '0;
            div_cnt_q <= DIV_LAST;
          end
        end
        ST_DIV: begin
          // restoring divide, one quotient bit a cycle shifted in behind the dividend
          rem_q     <= rem_ge ? COUNT_W'(rem_sh - {1'b0, divisor_q}) : rem_sh[COUNT_W-1:0];
          quo_q     <= {quo_q[MEAN_W-2:0], rem_ge};
          div_cnt_q <= div_cnt_q - 1'b1;
        end
        ST_NEWM: begin
          mean_q <= new_m[MEAN_W-1:0];
          a_q    <= a_m[MEAN_W+1] ? (MEAN_W + 1)'(-a_m) : a_m[MEAN_W:0];
          b_q    <= b_m[MEAN_W+1] ? (MEAN_W + 1)'(-b_m) : b_m[MEAN_W:0];
        end
        ST_MUL: begin
          prod_q <= a_q * b_q;
        end
        ST_ACC: begin
          spread_q <= spread_sum[SPREAD_W] ? '1 : spread_sum[SPREAD_W-1:0];
        end
        ST_FIN: begin
          if (fin_load) begin
            out_found_q  <= resp_q;
            out_peak_q   <= resp_q ? pk_q : '0;
            out_onset_q  <= resp_q ? low_q : '0;
            out_rise_q   <= resp_q ? rise : '0;
            out_mean_q   <= mean_q;
            out_spread_q <= spread_q;
          end
        end
        ST_DRAIN: ;
        default: ;
      endcase

      // running minimum; strict compare keeps the earliest lag on a tie
      if (rd_vld_q && (rd_first_q || ($signed(rd_val) < $signed(low_q)))) begin
        low_q     <= rd_val;
        low_lag_q <= rd_lag_q;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tdata  = {2'b00, out_spread_q, out_mean_q, out_rise_q, out_onset_q, out_peak_q};

  a_rd_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q == ST_SCAN))
    else $error("window read result without a scan issue");

  a_refr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    refr_q <= DEPTH_LAST)
    else $error("refractory count beyond window depth");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= DEPTH_CNT)
    else $error("fill count beyond window depth");

  a_found_lag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_found_q) |-> (out_rise_q != '0))
    else $error("response reported with zero rise lag");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (lag_q <= lim_q && lag_q != '0))
    else $error("scan lag outside search range");

endmodule

// ===== tb/scr_peak_onset_detector_test.sv =====
`timescale 1ns / 1ps
// scr_peak_onset_detector_test: self-checking bench for the peak and onset detector
// drives samples under random stalls and checks every result word against the directed table or a predictor
// depends on scr_pod_pkg and scr_peak_onset_detector
module scr_peak_onset_detector_test;
  import scr_pod_pkg::*;

  localparam int WINDOW_DEPTH = 96;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES  = 140;

  typedef struct packed {
    logic                found;
    logic [SAMPLE_W-1:0] peak;
    logic [SAMPLE_W-1:0] onset;
    logic [LAG_W-1:0]    lag;
    logic [MEAN_W-1:0]   mean;
    logic [SPREAD_W-1:0] spread;
  } scr_result_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                typed;
    scr_result_t         want;
  } stim_row_t;

  localparam scr_result_t NO_RESULT = '0;

  // threshold is the reset value throughout this table
  localparam stim_row_t DIRECTED [23] = '{
    '{32'h0000_0000, 1'b1, NO_RESULT},
    '{32'h7FFF_FFFF, 1'b1, NO_RESULT},
    '{32'h8000_0000, 1'b1, '{1'b1, 32'h7FFF_FFFF, 32'h0000_0000, 7'd2, 23'h02_0000, 48'h0}},
    '{32'h7FFF_FFFF, 1'b0, NO_RESULT},
    '{32'h0000_0064, 1'b1, '{1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 7'd2, 23'h02_0000, 48'h0}},
    '{32'h0000_0064, 1'b0, NO_RESULT},
    '{32'h0006_B661, 1'b0, NO_RESULT},  // rise equal to threshold
    '{32'h0000_0064, 1'b0, NO_RESULT},
    '{32'h0006_B662, 1'b0, NO_RESULT},  // one above threshold
    '{32'h0006_B661, 1'b0, NO_RESULT},
    '{32'h0006_B661, 1'b0, NO_RESULT},
    '{32'h0007_A120, 1'b0, NO_RESULT},  // plateau, not a strict max
    '{32'h0007_A120, 1'b0, NO_RESULT},
    '{32'h0000_0000, 1'b0, NO_RESULT},
    '{32'hAAAA_AAAA, 1'b0, NO_RESULT},
    '{32'h5555_5555, 1'b0, NO_RESULT},
    '{32'hAAAA_AAAA, 1'b0, NO_RESULT},
    '{32'hFFFF_FFFF, 1'b0, NO_RESULT},
    '{32'h8000_0001, 1'b0, NO_RESULT},
    '{32'hFFFF_FFF0, 1'b0, NO_RESULT},  // negative peak
    '{32'hFFFF_FF00, 1'b0, NO_RESULT},
    '{32'h0000_0001, 1'b0, NO_RESULT},
    '{32'h0000_0000, 1'b0, NO_RESULT}
  };

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [AMP_W-1:0]      cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [SAMPLE_W-1:0]   s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  scr_peak_onset_detector #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // detector model state
  logic [SAMPLE_W-1:0]        hist_mem [WINDOW_DEPTH];
  int                         hist_ptr;
  logic signed [SAMPLE_W-1:0] prev_sample;
  logic signed [SAMPLE_W-1:0] prev2_sample;
  int                         holdoff_q;
  logic [COUNT_W-1:0]         resp_count_q;
  logic [MEAN_W-1:0]          mean_q;
  logic [MEAN_W-1:0]          mean_prev_q;
  logic [SPREAD_W-1:0]        spread_q;
  logic [AMP_W-1:0]           min_rise_q;

  scr_result_t expected_results [$];
  int          samples_sent;
  int          responses_seen;
  int          words_checked;
  int          settings_used;
  int          error_count;
  int          cycle_count;
  logic        tx_idle_on;
  logic        rx_stall_on;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic scr_result_t predict_response(logic [SAMPLE_W-1:0] x);
    scr_result_t                r;
    logic signed [SAMPLE_W-1:0] pk;
    logic signed [SAMPLE_W-1:0] low;
    logic signed [SAMPLE_W-1:0] v;
    int                         low_lag;
    int                         span;
    longint                     t, m, diff, q, nm, a, b;
    logic [63:0]                prod, total;
    r = NO_RESULT;
    hist_ptr = (hist_ptr + 1) % WINDOW_DEPTH;
    hist_mem[hist_ptr] = x;
    if (holdoff_q > 0) holdoff_q--;
    if (prev_sample > prev2_sample && prev_sample > $signed(x)) begin
      pk = prev_sample;
      low = hist_mem[(hist_ptr + WINDOW_DEPTH - 1) % WINDOW_DEPTH];
      low_lag = 1;
      span = WINDOW_DEPTH - holdoff_q;
      for (int i = 1; i < span; i++) begin
        v = hist_mem[(hist_ptr + WINDOW_DEPTH - i) % WINDOW_DEPTH];
        if (v < low) begin
          low = v;
          low_lag = i;
        end
      end
      prev2_sample = prev_sample;
      prev_sample = x;
      if (longint'(pk) - longint'(low) > longint'(min_rise_q)) begin
        r.found = 1'b1;
        r.peak = pk;
        r.onset = low;
        r.lag = low_lag[LAG_W-1:0];
        holdoff_q = WINDOW_DEPTH - 1;
        // running mean and spread of the rise lag
        if (resp_count_q != '1) resp_count_q++;
        t = longint'(low_lag) << FRAC_W;
        m = longint'(mean_q);
        diff = t - m;
        q = diff / longint'(resp_count_q);
        nm = m + q;
        a = t - nm;
        b = t - longint'(mean_prev_q);
        if (a < 0) a = -a;
        if (b < 0) b = -b;
        prod = 64'(a * b) >> FRAC_W;
        total = {16'd0, spread_q} + prod;
        spread_q = (total > 64'hFFFF_FFFF_FFFF) ? '1 : total[SPREAD_W-1:0];
        mean_q = nm[MEAN_W-1:0];
        mean_prev_q = mean_q;
      end
    end else begin
      prev2_sample = prev_sample;
      prev_sample = x;
    end
    r.mean = mean_q;
    r.spread = spread_q;
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] to_sample(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic send_sample(logic [SAMPLE_W-1:0] sample, logic typed, scr_result_t want);
    scr_result_t predicted;
    if (tx_idle_on) begin
      // occasional long gap so the next word lands on any phase of the work
      if ($urandom_range(99) < 3) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 150)) @(posedge clk_i);
      end
      while ($urandom_range(99) < 21) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sample;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = predict_response(sample);
    expected_results.push_back(typed ? want : predicted);
    samples_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_min_rise(logic [AMP_W-1:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    min_rise_q = value;
    settings_used++;
  endtask

  task automatic send_bump();
    longint base, height;
    int     rise_n;
    case ($urandom_range(3))
      0:       base = longint'($urandom_range(131072)) - 65536;
      1:       base = longint'($urandom_range(33554432)) - 16777216;
      2:       base = longint'($signed($urandom));
      default: base = -64'sd2147483648 + longint'($urandom_range(1024));
    endcase
    case ($urandom_range(5))
      0:       height = longint'(min_rise_q);
      1:       height = longint'(min_rise_q) + 1;
      2:       height = longint'(min_rise_q) - 1;
      3:       height = longint'(min_rise_q) + longint'($urandom_range(1 << 20));
      4:       height = longint'($urandom_range(1 << 24)) + 1;
      default: height = longint'($urandom) + 1;
    endcase
    if (height < 1) height = 1;
    rise_n = $urandom_range(1, 6);
    repeat ($urandom_range(1, 2)) send_sample(to_sample(base), 1'b0, NO_RESULT);
    for (int i = 1; i <= rise_n; i++)
      send_sample(to_sample(base + height * i / rise_n), 1'b0, NO_RESULT);
    send_sample(to_sample(base + height / 2 - longint'($urandom_range(3))), 1'b0, NO_RESULT);
  endtask

  task automatic run_random(int count);
    int   stop_at;
    logic [SAMPLE_W-1:0] flat;
    stop_at = samples_sent + count;
    while (samples_sent < stop_at) begin
      case ($urandom_range(19))
        14, 15, 16: repeat ($urandom_range(1, 4)) send_sample($urandom, 1'b0, NO_RESULT);
        17, 18, 19: begin
          flat = $urandom;
          repeat ($urandom_range(2, 4)) send_sample(flat, 1'b0, NO_RESULT);
        end
        default: send_bump();
      endcase
    end
  endtask

  // result side: check, then decide the stall for the next cycle
  always @(posedge clk_i) begin
    scr_result_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[70:64],
             m_axis_tdata[93:71], m_axis_tdata[141:94]};
      words_checked++;
      if (m_axis_tuser) responses_seen++;
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result word: found=%0d peak=%h onset=%h lag=%0d",
                   got.found, got.peak, got.onset, got.lag);
      end else begin
        want = expected_results.pop_front();
        if (got.found !== want.found || got.peak !== want.peak ||
            got.onset !== want.onset || got.lag !== want.lag ||
            got.mean !== want.mean || got.spread !== want.spread ||
            m_axis_tdata[143:142] !== 2'b00) begin
          error_count++;
          if (error_count <= 10) begin
            $display("word %0d mismatch: expected found=%0d peak=%h onset=%h lag=%0d mean=%h spread=%h",
                     words_checked, want.found, want.peak, want.onset, want.lag,
                     want.mean, want.spread);
            $display("  actual found=%0d peak=%h onset=%h lag=%0d mean=%h spread=%h pad=%b",
                     got.found, got.peak, got.onset, got.lag, got.mean, got.spread,
                     m_axis_tdata[143:142]);
          end
        end
      end
    end
    m_axis_tready <= rx_stall_on ? ($urandom_range(99) >= 21) : 1'b1;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d words still expected",
             cycle_count, expected_results.size());
    $display("scr_peak_onset_detector_test NOT OK");
    $finish;
  end

  initial begin
    for (int i = 0; i < WINDOW_DEPTH; i++) hist_mem[i] = '0;
    hist_ptr = 0;
    prev_sample = '0;
    prev2_sample = '0;
    holdoff_q = 0;
    resp_count_q = '0;
    mean_q = '0;
    mean_prev_q = '0;
    spread_q = '0;
    min_rise_q = AMP_RESET;
    samples_sent = 0;
    responses_seen = 0;
    words_checked = 0;
    settings_used = 1;
    error_count = 0;
    cycle_count = 0;
    tx_idle_on = 1'b1;
    rx_stall_on = 1'b1;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) send_sample(DIRECTED[i].sample, DIRECTED[i].typed, DIRECTED[i].want);

    write_min_rise('0);
    run_random(120);

    write_min_rise('1);
    run_random(80);

    // long stretch with no idling on either side
    write_min_rise(AMP_W'($urandom_range(1, 1 << 20)));
    tx_idle_on = 1'b0;
    rx_stall_on = 1'b0;
    run_random(170);
    tx_idle_on = 1'b1;
    rx_stall_on = 1'b1;

    write_min_rise(AMP_RESET);
    run_random(80);
    drain_results();
    run_random(80);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("sent %0d samples over %0d threshold settings, checked %0d result words",
             samples_sent, settings_used, words_checked);
    $display("%0d responses detected, %0d failures", responses_seen, error_count);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("scr_peak_onset_detector_test OK");
    end else begin
      $display("scr_peak_onset_detector_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/scr_pod_pkg.sv
design/scr_peak_onset_detector.sv
tb/scr_peak_onset_detector_test.sv
